// ===== sv/rlc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlc_pkg
// Types and constants shared by the refill level controller modules.
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam int SEC_W = 10;
  localparam int SEL_W = 5;
  localparam int MS_W  = 32;

  typedef enum logic [2:0] {
    MODE_OK       = 3'd0,
    MODE_DEBOUNCE = 3'd1,
    MODE_REFILL   = 3'd2,
    MODE_OVERRUN  = 3'd3,
    MODE_TIMEOUT  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PUMP_KEEP = 2'd0,
    PUMP_OFF  = 2'd1,
    PUMP_ON   = 2'd2
  } pump_t;

  typedef enum logic [1:0] {
    ST_NO_SENSOR = 2'd0,
    ST_HALTED    = 2'd1,
    ST_STEPPED   = 2'd2,
    ST_REARMED   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_POLL  = 1'b0,
    CMD_REARM = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_OVERRUN  = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_SENSOR   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    status_t status;
    pump_t   pump;
    mode_t   mode;
    logic    take_now;
  } step_t;

endpackage

// ===== sv/rlc_step.sv =====
// ----------------------------------------------------------------------------
// rlc_step
// Next mode, pump command and status for one item of the refill machine.
// ----------------------------------------------------------------------------
module rlc_step import rlc_pkg::*; #(
  parameter int LIM_W = 30
) (
  input  mode_t             mode,
  input  logic [MS_W-1:0]   last_ms,
  input  logic              sensor_ok,
  input  logic [LIM_W-1:0]  lim_debounce,
  input  logic [LIM_W-1:0]  lim_overrun,
  input  logic [LIM_W-1:0]  lim_timeout,
  input  cmd_t              command,
  input  logic              high,
  input  logic [MS_W-1:0]   now_ms,
  output step_t             res
);

  localparam int CMP_W = (LIM_W > MS_W) ? LIM_W : MS_W;

  logic [MS_W-1:0]  delta;
  logic [CMP_W-1:0] delta_x;
  logic             over_deb;
  logic             over_ovr;
  logic             over_tmo;

  assign delta    = now_ms - last_ms;
  assign delta_x  = CMP_W'(delta);
  assign over_deb = delta_x > CMP_W'(lim_debounce);
  assign over_ovr = delta_x > CMP_W'(lim_overrun);
  assign over_tmo = delta_x > CMP_W'(lim_timeout);

  always_comb begin
    res.status   = ST_STEPPED;
    res.pump     = PUMP_KEEP;
    res.mode     = mode;
    res.take_now = 1'b0;
    if (command == CMD_REARM) begin
      res.status = ST_REARMED;
      res.mode   = MODE_OK;
    end else if (!sensor_ok) begin
      res.status = ST_NO_SENSOR;
    end else begin
      unique case (mode)
        MODE_OK: begin
          res.pump = PUMP_OFF;
          if (high) begin
            res.mode     = MODE_DEBOUNCE;
            res.take_now = 1'b1;
          end
        end
        MODE_DEBOUNCE: begin
          if (high && over_deb) begin
            res.pump     = PUMP_ON;
            res.mode     = MODE_REFILL;
            res.take_now = 1'b1;
          end else if (!high) begin
            res.mode = MODE_OK;
          end
        end
        MODE_REFILL: begin
          if (!high) begin
            res.mode     = MODE_OVERRUN;
            res.take_now = 1'b1;
          end else if (over_tmo) begin
            res.mode = MODE_TIMEOUT;
            res.pump = PUMP_OFF;
          end
        end
        MODE_OVERRUN: begin
          if (!high && over_ovr) begin
            res.mode = MODE_OK;
            res.pump = PUMP_OFF;
          end else if (high) begin
            res.mode = MODE_REFILL;
          end
        end
        default: begin
          res.status = ST_HALTED;
        end
      endcase
    end
  end

endmodule

// ===== sv/refill_level_controller.sv =====
// An item taken into the input register is loaded into the result register once
// that register is empty or being read; its result is then offered on out_valid.
// Throughput: one item per cycle with no gaps; the input stalls only while both
// the input register and the result register hold items and out_stall is high.
// Reset sets the mode to ok, the last switch time to zero and the hold limits
// and sensor select to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// refill_level_controller
// Five-mode refill machine driven by timestamped level-sensor polls.
// ----------------------------------------------------------------------------
module refill_level_controller import rlc_pkg::*; #(
  parameter int MS_PER_SECOND = 1000,
  parameter int SENSOR_COUNT  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SEC_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic              in_sensor_high,
  input  logic [MS_W-1:0]   in_now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [1:0]        out_pump_command,
  output logic [2:0]        out_mode
);

  localparam int LIM_W = SEC_W + $clog2(MS_PER_SECOND + 1);
  localparam logic [LIM_W-1:0] MS_K = LIM_W'(MS_PER_SECOND);

  logic [LIM_W-1:0] lim_deb_r;
  logic [LIM_W-1:0] lim_ovr_r;
  logic [LIM_W-1:0] lim_tmo_r;
  logic [SEL_W-1:0] sel_r;
  logic             sensor_ok;

  logic             s1_vld_r;
  cmd_t             s1_cmd_r;
  logic             s1_high_r;
  logic [MS_W-1:0]  s1_now_r;
  logic             s1_adv;
  logic             in_take;

  mode_t            mode_r;
  mode_t            mode_nxt;
  logic [MS_W-1:0]  last_ms_r;
  logic [MS_W-1:0]  last_ms_nxt;
  step_t            step;

  logic             out_vld_r;
  status_t          out_status_r;
  pump_t            out_pump_r;
  mode_t            out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_deb_r <= LIM_W'(3 * MS_PER_SECOND);
      lim_ovr_r <= LIM_W'(10 * MS_PER_SECOND);
      lim_tmo_r <= LIM_W'(30 * MS_PER_SECOND);
      sel_r     <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: lim_deb_r <= LIM_W'(cfg_wdata) * MS_K;
        CFG_OVERRUN:  lim_ovr_r <= LIM_W'(cfg_wdata) * MS_K;
        CFG_TIMEOUT:  lim_tmo_r <= LIM_W'(cfg_wdata) * MS_K;
        CFG_SENSOR:   sel_r     <= cfg_wdata[SEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign sensor_ok = !sel_r[SEL_W-1] &&
                     (32'(sel_r[SEL_W-2:0]) < 32'(SENSOR_COUNT));

  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_high_r <= in_sensor_high;
      s1_now_r  <= in_now_ms;
    end
  end

  rlc_step #(
    .LIM_W (LIM_W)
  ) u_step (
    .mode         (mode_r),
    .last_ms      (last_ms_r),
    .sensor_ok    (sensor_ok),
    .lim_debounce (lim_deb_r),
    .lim_overrun  (lim_ovr_r),
    .lim_timeout  (lim_tmo_r),
    .command      (s1_cmd_r),
    .high         (s1_high_r),
    .now_ms       (s1_now_r),
    .res          (step)
  );

  always_comb begin
    mode_nxt    = mode_r;
    last_ms_nxt = last_ms_r;
    if (s1_adv) begin
      mode_nxt = step.mode;
      if (step.take_now) begin
        last_ms_nxt = s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OK;
      last_ms_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      last_ms_r <= last_ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= step.status;
      out_pump_r   <= step.pump;
      out_mode_r   <= step.mode;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_status_r;
  assign out_pump_command = out_pump_r;
  assign out_mode         = out_mode_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("result register not loaded after advance");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with an empty input register");

  a_pump_on_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_pump_r == PUMP_ON) |-> out_mode_r == MODE_REFILL)
    else $error("pump driven on outside refill mode");

  a_timeout_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(mode_r) == MODE_TIMEOUT &&
     !($past(s1_adv) && $past(s1_cmd_r) == CMD_REARM)) |-> mode_r == MODE_TIMEOUT)
    else $error("timeout mode left without a rearm");

endmodule

// ===== verif/refill_level_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refill_level_controller_tb
// Drives timestamped sensor polls and rearm commands into the refill level
// controller, predicts every result from its own copy of the mode machine and
// registers, and checks each result in order, with sides idling at random in some phases.
// ----------------------------------------------------------------------------
module refill_level_controller_tb;
  import rlc_pkg::*;

  localparam int MS_PER_SECOND = 1000;
  localparam int SENSOR_COUNT  = 16;
  localparam int LATENCY       = 2;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TIMEOUT_NS    = 4_000_000;

  typedef struct {
    status_t status;
    pump_t   pump;
    mode_t   mode;
  } refill_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [SEC_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_command = 1'b0;
  logic             in_sensor_high = 1'b0;
  logic [MS_W-1:0]  in_now_ms = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [1:0]       out_pump_command;
  logic [2:0]       out_mode;

  // Predicted state and register copies.
  mode_t            m_mode = MODE_OK;
  logic [31:0]      m_last_ms = '0;
  logic [SEC_W-1:0] m_debounce_s = 10'd3;
  logic [SEC_W-1:0] m_overrun_s = 10'd10;
  logic [SEC_W-1:0] m_timeout_s = 10'd30;
  logic [SEL_W-1:0] m_sensor_sel = 5'h1F;

  refill_result_t   pending_results[$];
  refill_result_t   oldest;
  int               errors = 0;
  bit               gaps_on = 1'b0;
  bit               stalls_on = 1'b0;
  logic             hold_req = 1'b0;
  int               hold_cnt = 0;
  int               stall_left = 0;

  refill_level_controller #(
    .MS_PER_SECOND(MS_PER_SECOND),
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_sensor_high(in_sensor_high),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_pump_command(out_pump_command),
    .out_mode(out_mode)
  );

  always #5 clk = ~clk;

  function automatic bit sensor_assigned();
    int sel;
    sel = $signed(m_sensor_sel);
    return sel >= 0 && sel < SENSOR_COUNT;
  endfunction

  function automatic bit held_over(logic [31:0] delta, logic [SEC_W-1:0] secs);
    longint unsigned limit_ms;
    limit_ms = longint'(secs) * MS_PER_SECOND;
    return longint'(delta) > limit_ms;
  endfunction

  function automatic void advance_refill(cmd_t cmd, logic high, logic [31:0] now);
    refill_result_t r;
    logic [31:0] delta;
    r.status = ST_STEPPED;
    r.pump = PUMP_KEEP;
    delta = now - m_last_ms;
    if (cmd == CMD_REARM) begin
      m_mode = MODE_OK;
      r.status = ST_REARMED;
    end else if (!sensor_assigned()) begin
      r.status = ST_NO_SENSOR;
    end else begin
      case (m_mode)
        MODE_OK: begin
          r.pump = PUMP_OFF;
          if (high) begin
            m_mode = MODE_DEBOUNCE;
            m_last_ms = now;
          end
        end
        MODE_DEBOUNCE: begin
          if (high && held_over(delta, m_debounce_s)) begin
            r.pump = PUMP_ON;
            m_last_ms = now;
            m_mode = MODE_REFILL;
          end else if (!high) begin
            m_mode = MODE_OK;
          end
        end
        MODE_REFILL: begin
          if (!high) begin
            m_mode = MODE_OVERRUN;
            m_last_ms = now;
          end else if (held_over(delta, m_timeout_s)) begin
            m_mode = MODE_TIMEOUT;
            r.pump = PUMP_OFF;
          end
        end
        MODE_OVERRUN: begin
          if (!high && held_over(delta, m_overrun_s)) begin
            m_mode = MODE_OK;
            r.pump = PUMP_OFF;
          end else if (high) begin
            m_mode = MODE_REFILL;
          end
        end
        default: r.status = ST_HALTED;
      endcase
    end
    r.mode = m_mode;
    pending_results.push_back(r);
  endfunction

  function automatic int pick_idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Input side: every accepted item advances the predicted machine.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      advance_refill(cmd_t'(in_command), in_sensor_high, in_now_ms);
    end
  end

  // Result side: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: status %0d pump %0d mode %0d",
               out_status, out_pump_command, out_mode);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          errors++;
        end
        if (out_pump_command !== oldest.pump) begin
          $error("pump_command: expected %0d, got %0d", oldest.pump, out_pump_command);
          errors++;
        end
        if (out_mode !== oldest.mode) begin
          $error("mode: expected %0d, got %0d", oldest.mode, out_mode);
          errors++;
        end
      end
    end
  end

  // Receiver stalls, with a long hold-off on request.
  always @(posedge clk) begin
    if (!hold_req) hold_cnt = 0;
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_idle_len();
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_item(cmd_t cmd, logic high, logic [31:0] now);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sensor_high <= high;
    in_now_ms <= now;
    do @(posedge clk); while (in_stall);
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() > 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
      pending_results.delete();
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [SEC_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE: m_debounce_s = value;
      CFG_OVERRUN:  m_overrun_s = value;
      CFG_TIMEOUT:  m_timeout_s = value;
      CFG_SENSOR:   m_sensor_sel = value[SEL_W-1:0];
      default: ;
    endcase
  endtask

  // Only called while the block is idle; upper data bits of the sensor write
  // are random since that register keeps only its low bits.
  task automatic set_config(int deb, int ovr, int tmo, logic [SEL_W-1:0] sel);
    write_reg(CFG_DEBOUNCE, SEC_W'(deb));
    write_reg(CFG_OVERRUN, SEC_W'(ovr));
    write_reg(CFG_TIMEOUT, SEC_W'(tmo));
    write_reg(CFG_SENSOR, {5'($urandom), sel});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_no_sensor();
    send_item(CMD_POLL, 1'b1, 32'd0);
    send_item(CMD_POLL, 1'b0, 32'hFFFF_FFFF);
    send_item(CMD_REARM, 1'b1, 32'h8000_0000);
    drain();
  endtask

  task automatic test_mode_walk();
    set_config(1, 1, 2, 5'd15);
    send_item(CMD_POLL, 1'b1, 32'd100);
    send_item(CMD_POLL, 1'b1, 32'd1100);
    send_item(CMD_POLL, 1'b1, 32'd1101);
    send_item(CMD_POLL, 1'b1, 32'd3101);
    send_item(CMD_POLL, 1'b1, 32'd3102);
    send_item(CMD_POLL, 1'b0, 32'd9999);
    send_item(CMD_REARM, 1'b0, 32'd0);
    send_item(CMD_POLL, 1'b0, 32'd10000);
    send_item(CMD_POLL, 1'b1, 32'hFFFF_FF00);
    send_item(CMD_POLL, 1'b0, 32'hFFFF_FF10);
    send_item(CMD_POLL, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_POLL, 1'b1, 32'd1000);
    send_item(CMD_POLL, 1'b0, 32'd1500);
    send_item(CMD_POLL, 1'b1, 32'd1600);
    send_item(CMD_POLL, 1'b0, 32'd1700);
    send_item(CMD_POLL, 1'b0, 32'd2700);
    send_item(CMD_POLL, 1'b0, 32'd2701);
    drain();
    set_config(0, 0, 0, 5'd0);
    send_item(CMD_POLL, 1'b1, 32'd0);
    send_item(CMD_POLL, 1'b1, 32'd0);
    send_item(CMD_POLL, 1'b1, 32'd1);
    send_item(CMD_POLL, 1'b1, 32'd2);
    send_item(CMD_REARM, 1'b1, 32'd2);
    drain();
    set_config(999, 999, 999, 5'h10);
    send_item(CMD_POLL, 1'b1, 32'd5);
    drain();
  endtask

  task automatic run_random_phase(int deb, int ovr, int tmo, logic [SEL_W-1:0] sel,
                                  int count, bit idle);
    logic [31:0] clock_ms;
    logic [31:0] now;
    logic        level;
    logic        high;
    cmd_t        cmd;
    int          run_left;
    int          step_max;
    int          hold_max;
    int          r;
    set_config(deb, ovr, tmo, sel);
    gaps_on = idle;
    stalls_on = idle;
    hold_max = deb > ovr ? deb : ovr;
    hold_max = hold_max > tmo ? hold_max : tmo;
    step_max = hold_max * MS_PER_SECOND / 2 + 1500;
    clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3 * step_max)
                                           : $urandom;
    level = 1'b0;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        level = ~level;
        run_left = $urandom_range(1, 8);
      end
      r = $urandom_range(0, 99);
      if (r < 5 || (m_mode == MODE_TIMEOUT && r < 30)) begin
        cmd = CMD_REARM;
        high = 1'($urandom);
        now = $urandom;
      end else if (r < 13) begin
        cmd = CMD_POLL;
        high = 1'($urandom);
        now = $urandom;
      end else begin
        cmd = CMD_POLL;
        clock_ms += $urandom_range(0, step_max);
        high = level;
        now = clock_ms;
        run_left--;
      end
      send_item(cmd, high, now);
    end
    drain();
  endtask

  task automatic test_random_polls();
    run_random_phase(0, 0, 0, 5'd0, 60, 1'b1);
    run_random_phase(1, 2, 5, 5'd7, 60, 1'b1);
    run_random_phase(3, 10, 30, 5'd15, 60, 1'b0);
    run_random_phase(2, 1, 3, 5'h1F, 30, 1'b1);
    run_random_phase(999, 999, 999, 5'd9, 50, 1'b1);
    run_random_phase(0, 999, 0, 5'd3, 50, 1'b1);
    run_random_phase(1, 1, 1, 5'h10, 20, 1'b0);
    run_random_phase(2, 0, 4, 5'd12, 60, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [31:0] clock_ms;
    set_config(0, 0, 1, 5'd5);
    gaps_on = 1'b0;
    stalls_on = 1'b1;
    hold_req <= 1'b1;
    clock_ms = $urandom;
    for (int i = 0; i < 40; i++) begin
      clock_ms += $urandom_range(0, 800);
      send_item(CMD_POLL, 1'($urandom_range(0, 3) != 0), clock_ms);
    end
    hold_req <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_sensor();
    test_mode_walk();
    test_random_polls();
    test_backpressure();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rlc_pkg.sv
sv/rlc_step.sv
sv/refill_level_controller.sv
verif/refill_level_controller_tb.sv
